@@ design/qrhd_pkg.sv @@
// Package for the quasi-random hemisphere direction block.
// Holds the fixed-point constants shared by the design; no dependencies.
package qrhd_pkg;

  localparam logic signed [47:0] StepC30  = 48'sd929887697;
  localparam logic signed [47:0] OneQ30   = 48'sd1073741824;
  localparam logic signed [47:0] HalfQ30  = 48'sd536870912;
  localparam logic [31:0]        OneQ30U  = 32'd1073741824;
  localparam int unsigned        NumDigits = 16;

endpackage

@@ design/quasi_random_hemisphere_direction_top.sv @@
// Top level of the quasi-random cosine-weighted hemisphere direction generator.
// Depends on qrhd_pkg for its fixed-point constants.
//
// The slave channel takes one item per request: tuser carries the restart flag
// and tdata the normal, tangent and bitangent in signed Q1.15. The master channel
// returns one item with the direction (Q2.15), the accepted disc point and
// cos_theta. A small sequencer drives one adder per axis over the base-4 digits
// of the sample counter, one digit per cycle, at most 16 digits per drawn point,
// and draws a new point whenever one falls outside the disc. A restoring square
// root then resolves one bit per cycle, and a single 17x16 multiplier forms the
// nine products of the direction. The block is not ready while an item is at
// work. Reset clears the sample counter and the sequencer.
// A finished result waits in the output register while the receiver stalls,
// and the next item is accepted once that result has been taken.
module quasi_random_hemisphere_direction_top #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // normal_x, normal_y, normal_z, tangent_x..z, bitangent_x..z from bit 0 up
  input  logic [143:0] s_axis_tdata,
  // restart
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dir_x, dir_y, dir_z, disc_x, disc_y, cos_theta from bit 0 up, zero filled
  output logic [103:0] m_axis_tdata
);
  import qrhd_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDigit, StRound, StCheck, StSqrt, StFix, StMul, StOut
  } state_e;

  state_e                  state_q;
  logic [INDEX_BITS-1:0]   index_q;
  logic [INDEX_BITS-1:0]   digits_q;
  logic [4:0]              k_q;
  logic                    neg_q;
  logic signed [47:0]      ax_q, ay_q;
  logic                    sel_q;
  logic signed [16:0]      x_q, y_q;
  logic [31:0]             t_q;
  logic [16:0]             s_q;
  logic [4:0]              bit_q;
  logic [1:0]              term_q;
  logic [1:0]              comp_q;
  logic signed [15:0]      vec_q [9];
  logic signed [47:0]      acc_q;
  logic signed [16:0]      dir_q [3];
  logic [15:0]             cos_q;
  logic                    valid_q;

  logic [1:0]              dig;
  logic signed [47:0]      sx, sy, addx, addy, racc, rnd;
  logic signed [47:0]      radd;
  logic signed [16:0]      rq;
  logic [16:0]             cand;
  logic [33:0]             sq;
  logic signed [16:0]      mop_a;
  logic signed [15:0]      mop_b;
  logic signed [32:0]      prod;
  logic signed [47:0]      acc_n, dr;
  logic signed [34:0]      r2;

  assign dig = digits_q[1:0];
  always_comb begin
    case (dig)
      2'd2:    sx = StepC30;
      2'd3:    sx = -StepC30;
      default: sx = '0;
    endcase
    case (dig)
      2'd1:    sy = OneQ30;
      2'd2, 2'd3: sy = -HalfQ30;
      default: sy = '0;
    endcase
    addx = (sx <<< (16 - k_q));
    addy = (sy <<< (16 - k_q));
    // Rounding of the accumulated point, one axis per cycle.
    racc = sel_q ? ay_q : ax_q;
    radd = racc + (48'sd1 <<< 30);
    rnd  = radd >>> 31;
    rq   = rnd[16:0];
    cand = s_q | (17'd1 << bit_q);
    sq   = cand * cand;
    r2   = x_q * x_q + y_q * y_q;
    mop_a = (term_q == 2'd0) ? $signed({1'b0, cos_q}) :
            (term_q == 2'd1) ? x_q : y_q;
    mop_b = vec_q[4'(term_q) * 4'd3 + 4'(comp_q)];
    prod  = mop_a * mop_b;
    acc_n = ((term_q == 2'd0) ? 48'sd0 : acc_q) + 48'(prod);
    dr    = (acc_n + 48'sd16384) >>> 15;
  end

  assign s_axis_tready = (state_q == StIdle) && !valid_q;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'b0, cos_q, y_q[15:0], x_q[15:0], dir_q[2], dir_q[1], dir_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      index_q <= '0;
      valid_q <= 1'b0;
      digits_q <= '0;
      k_q <= '0;
      neg_q <= 1'b0;
      sel_q <= 1'b0;
      bit_q <= '0;
      term_q <= '0;
      comp_q <= '0;
    end else begin
      if (valid_q && m_axis_tready) valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            for (int i = 0; i < 9; i++) vec_q[i] <= s_axis_tdata[16*i +: 16];
            digits_q <= s_axis_tuser ? '0 : index_q;
            index_q  <= s_axis_tuser ? INDEX_BITS'(1) : index_q + 1'b1;
            ax_q <= '0; ay_q <= '0; k_q <= '0; neg_q <= 1'b0;
            state_q <= StDigit;
          end
        end
        StDigit: begin
          if (digits_q == '0 || k_q == 5'(NumDigits)) begin
            sel_q <= 1'b0;
            state_q <= StRound;
          end else begin
            ax_q <= neg_q ? ax_q - addx : ax_q + addx;
            ay_q <= neg_q ? ay_q - addy : ay_q + addy;
            if (dig == 2'd0) neg_q <= !neg_q;
            k_q <= k_q + 1'b1;
            digits_q <= digits_q >> 2;
          end
        end
        StRound: begin
          if (!sel_q) begin
            x_q <= rq;
            sel_q <= 1'b1;
          end else begin
            y_q <= rq;
            state_q <= StCheck;
          end
        end
        StCheck: begin
          if (r2 < 35'(OneQ30U)) begin
            t_q <= OneQ30U - r2[31:0];
            s_q <= '0;
            bit_q <= 5'd15;
            state_q <= StSqrt;
          end else begin
            digits_q <= index_q;
            index_q <= index_q + 1'b1;
            ax_q <= '0; ay_q <= '0; k_q <= '0; neg_q <= 1'b0;
            state_q <= StDigit;
          end
        end
        StSqrt: begin
          if (34'(sq) <= 34'(t_q)) s_q <= cand;
          if (bit_q == 5'd0) state_q <= StFix;
          else bit_q <= bit_q - 1'b1;
        end
        StFix: begin
          if (s_q < 17'd32768 &&
              34'(s_q + 1'b1) * 34'(s_q + 1'b1) <= 34'(t_q)) begin
            s_q <= s_q + 1'b1;
          end else begin
            cos_q <= (34'(t_q) - 34'(s_q) * 34'(s_q) > 34'(s_q)) ? 16'(s_q + 1'b1)
                                                                : s_q[15:0];
            term_q <= '0;
            comp_q <= '0;
            state_q <= StMul;
          end
        end
        StMul: begin
          acc_q <= acc_n;
          if (term_q == 2'd2) begin
            dir_q[comp_q] <= (dr > 48'sd65535) ? 17'sd65535 :
                             (dr < -48'sd65536) ? -17'sd65536 : dr[16:0];
            term_q <= '0;
            if (comp_q == 2'd2) state_q <= StOut;
            else comp_q <= comp_q + 1'b1;
          end else begin
            term_q <= term_q + 1'b1;
          end
        end
        StOut: begin
          valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

@@ verif/quasi_random_hemisphere_direction_top_test.sv @@
// Testbench for the quasi-random hemisphere direction generator top level.
// Predicts each direction, disc point and cos_theta from its own model of the
// sample counter and checks every result item in order; depends only on the RTL.
module quasi_random_hemisphere_direction_top_test;

  localparam int unsigned IndexBits = 32;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [15:0] bz, by, bx, tz, ty, tx, nz, ny, nx;
  } basis_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic [15:0]        cos_theta;
    logic signed [15:0] disc_y;
    logic signed [15:0] disc_x;
    logic signed [16:0] dir_z;
    logic signed [16:0] dir_y;
    logic signed [16:0] dir_x;
  } direction_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;

  logic [31:0]  model_index;
  direction_t   expected_dirs[$];
  int           mismatch_count;
  int           idle_cycles;
  bit           timed_out;
  bit           calm;

  quasi_random_hemisphere_direction_top #(.INDEX_BITS(IndexBits)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic longint round_div(longint v, int s);
    longint t;
    t = v + (longint'(1) << (s - 1));
    return t >>> s;
  endfunction

  function automatic void draw_point(logic [31:0] n, output longint px, output longint py);
    longint ax, ay, sx, sy;
    bit neg;
    logic [1:0] d;
    ax = 0;
    ay = 0;
    neg = 0;
    for (int k = 0; k < 16 && n != 0; k++) begin
      d = n[1:0];
      case (d)
        2'd0: begin sx = 0; sy = 0; end
        2'd1: begin sx = 0; sy = 1073741824; end
        2'd2: begin sx = 929887697; sy = -536870912; end
        default: begin sx = -929887697; sy = -536870912; end
      endcase
      sx = sx <<< (16 - k);
      sy = sy <<< (16 - k);
      if (neg) begin
        ax -= sx;
        ay -= sy;
      end else begin
        ax += sx;
        ay += sy;
      end
      if (d == 2'd0) neg = !neg;
      n = n >> 2;
    end
    px = round_div(ax, 31);
    py = round_div(ay, 31);
  endfunction

  function automatic longint isqrt_round(longint t);
    longint s, c;
    s = 0;
    for (int b = 15; b >= 0; b--) begin
      c = s | (longint'(1) << b);
      if (c * c <= t) s = c;
    end
    if (s < 32768 && (s + 1) * (s + 1) <= t) s++;
    if (t - s * s > s) s++;
    return s;
  endfunction

  function automatic logic [16:0] combine(longint n, longint c, longint u, longint x,
                                          longint v, longint y);
    longint r;
    r = round_div(n * c + u * x + v * y, 15);
    if (r > 65535) r = 65535;
    if (r < -65536) r = -65536;
    return r[16:0];
  endfunction

  function automatic direction_t predict_direction(bit restart, basis_t b);
    direction_t o;
    longint x, y, r2, cs;
    if (restart) model_index = '0;
    for (int a = 0; a < 4; a++) begin
      draw_point(model_index, x, y);
      model_index = model_index + 1;
      r2 = x * x + y * y;
      if (r2 < 64'sd1073741824) break;
    end
    if (r2 > 64'sd1073741824) r2 = 64'sd1073741824;
    cs = isqrt_round(64'sd1073741824 - r2);
    o = '0;
    o.dir_x = combine(b.nx, cs, b.tx, x, b.bx, y);
    o.dir_y = combine(b.ny, cs, b.ty, x, b.by, y);
    o.dir_z = combine(b.nz, cs, b.tz, x, b.bz, y);
    o.disc_x = x[15:0];
    o.disc_y = y[15:0];
    o.cos_theta = cs[15:0];
    return o;
  endfunction

  task automatic send_request(bit restart, basis_t b);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_dirs.push_back(predict_direction(restart, b));
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic basis_t random_basis();
    basis_t b;
    b = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    if ($urandom_range(3) == 0) begin
      b.nx = pick_value(); b.ny = pick_value(); b.nz = pick_value();
      b.tx = pick_value(); b.ty = pick_value(); b.tz = pick_value();
      b.bx = pick_value(); b.by = pick_value(); b.bz = pick_value();
    end
    return b;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_dirs.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    basis_t b;
    send_request(1'b1, '0);
    send_request(1'b0, {9{16'h7fff}});
    send_request(1'b0, {9{16'h8000}});
    b = '0;
    b.nz = 16'h7fff; b.tx = 16'h7fff; b.by = 16'h7fff;
    for (int i = 0; i < 12; i++) send_request(1'b0, b);
    send_request(1'b1, b);
    send_request(1'b0, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                        16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send_request(1'b1, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                        16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_request(1'b0, random_basis());
    wait_drained();
  endtask

  task automatic test_random_stream(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= 300 && i < 450);
      send_request($urandom_range(15) == 0, random_basis());
    end
    calm = 0;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 21);
  end

  always @(posedge clk_i) begin
    direction_t got, exp_dir;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_dirs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result item %h", m_axis_tdata);
      end else begin
        exp_dir = expected_dirs.pop_front();
        if (got.dir_x !== exp_dir.dir_x || got.dir_y !== exp_dir.dir_y ||
            got.dir_z !== exp_dir.dir_z || got.disc_x !== exp_dir.disc_x ||
            got.disc_y !== exp_dir.disc_y || got.cos_theta !== exp_dir.cos_theta) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch: expected dir %0d %0d %0d disc %0d %0d cos %0d, ",
                      "got %0d %0d %0d disc %0d %0d cos %0d"},
                     exp_dir.dir_x, exp_dir.dir_y, exp_dir.dir_z, exp_dir.disc_x,
                     exp_dir.disc_y, exp_dir.cos_theta, got.dir_x, got.dir_y,
                     got.dir_z, got.disc_x, got.disc_y, got.cos_theta);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1;
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    model_index = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    timed_out = 0;
    calm = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_drain_pause();
    test_random_stream(1130);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && expected_dirs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
